// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

    // Result queue depth; must be a power of two and at least 4.
    localparam int B64D_FIFO_DEPTH = 8;

    // Most results one character can cause (a full group).
    localparam int B64D_MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       out_last;
    } t_result;

    typedef struct packed {
        logic [1:0]                         count;
        t_result [B64D_MAX_RESULTS-1:0]     res;
    } t_emit;

endpackage

// ===== rtl/b64d_if.sv =====
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       msg_end;

    modport source (output valid, output char_in, output msg_end, input ready);
    modport sink   (input valid, input char_in, input msg_end, output ready);
endinterface

interface b64d_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       out_last;

    modport source (output valid, output data_byte, output byte_valid, output out_last,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input out_last,
                    output ready);
endinterface

// ===== rtl/b64d_map.sv =====
module b64d_map (
    input  logic [7:0] i_char,
    output logic       o_is_b64,
    output logic [5:0] o_sextet
);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    // 'a' maps to 26, '0' to 52
    localparam logic [7:0] LOWER_BIAS = 8'd71;
    localparam logic [7:0] DIGIT_BIAS = 8'd4;

    always_comb begin
        o_is_b64 = 1'b1;
        o_sextet = 6'd0;
        if (i_char >= CH_UPPER_A && i_char <= CH_UPPER_Z) begin
            o_sextet = 6'(i_char - CH_UPPER_A);
        end else if (i_char >= CH_LOWER_A && i_char <= CH_LOWER_Z) begin
            o_sextet = 6'(i_char - LOWER_BIAS);
        end else if (i_char >= CH_DIGIT_0 && i_char <= CH_DIGIT_9) begin
            o_sextet = 6'(i_char + DIGIT_BIAS);
        end else if (i_char == CH_PLUS) begin
            o_sextet = 6'd62;
        end else if (i_char == CH_SLASH) begin
            o_sextet = 6'd63;
        end else begin
            o_is_b64 = 1'b0;
        end
    end

endmodule

// ===== rtl/b64d_unpack.sv =====
module b64d_unpack
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_last,
    input  logic       i_is_b64,
    input  logic [5:0] i_sextet,
    output t_emit      o_emit
);

    logic [5:0] r_s0, r_s1, r_s2;
    logic [1:0] r_cnt, n_cnt;
    logic       r_stopped, n_stopped;

    logic       keep;
    logic       full;
    logic [1:0] cnt_after;
    logic [5:0] e0, e1, e2;
    logic [7:0] b0, b1, b2;

    assign keep = !r_stopped && i_is_b64;
    assign full = keep && (r_cnt == 2'd3);

    // Group contents as they stand after this character is stored.
    assign e0 = (keep && r_cnt == 2'd0) ? i_sextet : r_s0;
    assign e1 = (keep && r_cnt == 2'd1) ? i_sextet : r_s1;
    assign e2 = (keep && r_cnt == 2'd2) ? i_sextet : r_s2;

    assign b0 = {e0, e1[5:4]};
    assign b1 = {e1[3:0], e2[5:2]};
    assign b2 = {e2[1:0], i_sextet};

    always_comb begin
        cnt_after = r_cnt;
        n_stopped = r_stopped;
        if (full) begin
            cnt_after = 2'd0;
        end else if (keep) begin
            cnt_after = r_cnt + 2'd1;
        end else begin
            n_stopped = 1'b1;
        end

        o_emit = '0;
        if (full) begin
            o_emit.count  = 2'd3;
            o_emit.res[0] = '{data_byte: b0, byte_valid: 1'b1, out_last: 1'b0};
            o_emit.res[1] = '{data_byte: b1, byte_valid: 1'b1, out_last: 1'b0};
            o_emit.res[2] = '{data_byte: b2, byte_valid: 1'b1, out_last: i_last};
        end else if (i_last) begin
            // tail of the message: n kept values give n-1 bytes
            case (cnt_after)
                2'd3: begin
                    o_emit.count  = 2'd2;
                    o_emit.res[0] = '{data_byte: b0, byte_valid: 1'b1, out_last: 1'b0};
                    o_emit.res[1] = '{data_byte: b1, byte_valid: 1'b1, out_last: 1'b1};
                end
                2'd2: begin
                    o_emit.count  = 2'd1;
                    o_emit.res[0] = '{data_byte: b0, byte_valid: 1'b1, out_last: 1'b1};
                end
                default: begin
                    o_emit.count  = 2'd1;
                    o_emit.res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, out_last: 1'b1};
                end
            endcase
        end

        n_cnt = i_last ? 2'd0 : cnt_after;
        if (i_last) begin
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= 2'd0;
            r_stopped <= 1'b0;
        end else if (i_take) begin
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && keep) begin
            unique case (r_cnt)
                2'd0:    r_s0 <= i_sextet;
                2'd1:    r_s1 <= i_sextet;
                2'd2:    r_s2 <= i_sextet;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/b64d_fifo.sv =====
module b64d_fifo
    import b64d_pkg::*;
#(
    parameter int DEPTH = B64D_FIFO_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_emit   i_emit,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [1:0]      push_n;
    logic            pop_ok;

    assign push_n  = i_push ? i_emit.count : 2'd0;
    assign pop_ok  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // room for a full group regardless of what leaves this cycle
    assign o_room  = (r_count <= CW'(DEPTH - B64D_MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(push_n);
            r_rd_ptr <= r_rd_ptr + PW'(pop_ok);
            r_count  <= r_count + CW'(push_n) - CW'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < B64D_MAX_RESULTS; k++) begin
            if (k < int'(push_n)) begin
                r_mem[r_wr_ptr + PW'(k)] <= i_emit.res[k];
            end
        end
    end

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// Base64 stream decoder (standard alphabet A-Z a-z 0-9 + /).
//
// Input channel i_char: one ASCII character per request, msg_end set on the
// final character of a message. Output channel o_res: one decoded byte per
// request; byte_valid=0 marks an empty end-of-message marker, out_last flags
// the final result of each message.
//
// Every fourth alphabet character releases three bytes. The first '=' or
// non-alphabet character halts decoding until msg_end; on msg_end a partial
// group of n values gives n-1 bytes, or one empty marker if it gives none.
//
// Throughput: one character per cycle while the queue has room. Decode is a
// single combinational pass into a FIFO_DEPTH-entry result queue that drains
// one byte per cycle; input ready drops while fewer than three queue slots are
// free, so a stalled receiver backs up into the sender without loss. Four
// characters yield at most three bytes, so the queue keeps up with a continuous
// stream.
// Reset (synchronous, active low) empties the queue and clears group state.
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int FIFO_DEPTH = B64D_FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64d_char_if.sink    i_char,
    b64d_res_if.source   o_res
);

    logic       take;
    logic       room;
    logic       is_b64;
    logic [5:0] sextet;
    t_emit      emit;
    t_result    head;

    // accept whenever a full group of results still fits in the queue
    assign i_char.ready = room;
    assign take         = i_char.valid && room;

    // character to 6-bit value
    b64d_map u_map (
        .i_char   (i_char.char_in),
        .o_is_b64 (is_b64),
        .o_sextet (sextet)
    );

    // group state and byte assembly
    b64d_unpack u_unpack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_last   (i_char.msg_end),
        .i_is_b64 (is_b64),
        .i_sextet (sextet),
        .o_emit   (emit)
    );

    // result queue, up to three pushes per cycle, one pop
    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_res.valid),
        .i_pop   (o_res.ready),
        .o_head  (head)
    );

    assign o_res.data_byte  = head.data_byte;
    assign o_res.byte_valid = head.byte_valid;
    assign o_res.out_last   = head.out_last;

endmodule
